FILE: sv/assert_macros.svh
// Assertion helpers for the RTL, included by masked_row_to_mod_cells_unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is held
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: sv/mrmc_pkg.sv
`default_nettype none
package mrmc_pkg;

    // Row storage: [channel][field], field 0 note, 1 instrument, 2 effect, 3 parameter
    typedef logic [3:0][3:0][7:0] t_row_bytes;

    // Completed-row event from the parser
    typedef struct packed {
        logic       done;
        t_row_bytes bytes;
    } t_row_evt;

    localparam logic [7:0] NOTE_COUNT      = 8'd60;
    localparam logic [7:0] HIGH_NOTE_LIMIT = 8'd48;
    localparam logic [7:0] HIGH_NOTE_DROP  = 8'd24;
    localparam logic [1:0] LAST_CHANNEL    = 2'd3;

    // Mask byte bit 7 selects the lowest slot of its half
    function automatic logic [7:0] rev8(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = b[7-i];
        end
        return r;
    endfunction

    // Period table, indexed by note minus one
    function automatic logic [9:0] note_period(input logic [5:0] idx);
        logic [9:0] p;
        unique case (idx)
            6'd0:  p = 10'd856;  6'd1:  p = 10'd808;  6'd2:  p = 10'd762;
            6'd3:  p = 10'd720;  6'd4:  p = 10'd678;  6'd5:  p = 10'd640;
            6'd6:  p = 10'd604;  6'd7:  p = 10'd570;  6'd8:  p = 10'd538;
            6'd9:  p = 10'd508;  6'd10: p = 10'd480;  6'd11: p = 10'd453;
            6'd12: p = 10'd428;  6'd13: p = 10'd404;  6'd14: p = 10'd381;
            6'd15: p = 10'd360;  6'd16: p = 10'd339;  6'd17: p = 10'd320;
            6'd18: p = 10'd302;  6'd19: p = 10'd285;  6'd20: p = 10'd269;
            6'd21: p = 10'd254;  6'd22: p = 10'd240;  6'd23: p = 10'd226;
            6'd24: p = 10'd214;  6'd25: p = 10'd202;  6'd26: p = 10'd190;
            6'd27: p = 10'd180;  6'd28: p = 10'd170;  6'd29: p = 10'd160;
            6'd30: p = 10'd151;  6'd31: p = 10'd143;  6'd32: p = 10'd135;
            6'd33: p = 10'd127;  6'd34: p = 10'd120;  6'd35: p = 10'd113;
            6'd36: p = 10'd107;  6'd37: p = 10'd101;  6'd38: p = 10'd95;
            6'd39: p = 10'd90;   6'd40: p = 10'd85;   6'd41: p = 10'd80;
            6'd42: p = 10'd76;   6'd43: p = 10'd71;   6'd44: p = 10'd67;
            6'd45: p = 10'd64;   6'd46: p = 10'd60;   6'd47: p = 10'd57;
            6'd48: p = 10'd53;   6'd49: p = 10'd50;   6'd50: p = 10'd47;
            6'd51: p = 10'd45;   6'd52: p = 10'd42;   6'd53: p = 10'd40;
            6'd54: p = 10'd37;   6'd55: p = 10'd35;   6'd56: p = 10'd33;
            6'd57: p = 10'd31;   6'd58: p = 10'd30;   6'd59: p = 10'd28;
            default: p = 10'd0;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

FILE: sv/mrmc_parser.sv
`default_nettype none
module mrmc_parser (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire logic [7:0]          i_byte,
    input  wire logic                i_start,
    input  wire logic                i_emit_busy,
    output logic                     o_ready,
    output mrmc_pkg::t_row_evt       o_evt
);

    localparam logic [1:0] PH_MASK_HI = 2'd0;
    localparam logic [1:0] PH_MASK_LO = 2'd1;
    localparam logic [1:0] PH_FIELDS  = 2'd2;
    localparam logic [1:0] PH_UNUSED  = 2'd3;

    logic [1:0]           r_phase, n_phase;
    // Remaining present slots, bit k = slot k
    logic [15:0]          r_rem, n_rem;
    mrmc_pkg::t_row_bytes r_fields, n_fields;

    logic        w_accept;
    logic [1:0]  w_phase;
    logic [15:0] w_rem_low;
    logic [15:0] w_rem_left;
    logic        w_done;

    // Lowest pending slot and what is left after it
    assign w_rem_low  = r_rem & (~r_rem + 16'd1);
    assign w_rem_left = r_rem & ~w_rem_low;

    // Hold off only a byte that could finish a row while the last one drains
    assign o_ready = !i_emit_busy || (r_phase == PH_MASK_HI) || (r_phase == PH_UNUSED)
                     || ((r_phase == PH_FIELDS) && (w_rem_left != 16'd0));
    assign w_accept = i_valid && o_ready;
    assign w_phase  = (i_start || (r_phase == PH_UNUSED)) ? PH_MASK_HI : r_phase;

    // Parser next state
    always_comb begin
        n_phase  = r_phase;
        n_rem    = r_rem;
        n_fields = r_fields;
        w_done   = 1'b0;
        if (w_accept) begin
            unique case (w_phase)
                PH_MASK_HI: begin
                    n_rem    = {8'h00, mrmc_pkg::rev8(i_byte)};
                    n_fields = '0;
                    n_phase  = PH_MASK_LO;
                end
                PH_MASK_LO: begin
                    n_rem = {mrmc_pkg::rev8(i_byte), r_rem[7:0]};
                    if (n_rem == 16'd0) begin
                        w_done  = 1'b1;
                        n_phase = PH_MASK_HI;
                    end else begin
                        n_phase = PH_FIELDS;
                    end
                end
                PH_FIELDS: begin
                    for (int i = 0; i < 16; i++) begin
                        if (w_rem_low[i]) begin
                            n_fields[i/4][i%4] = i_byte;
                        end
                    end
                    n_rem = w_rem_left;
                    if (w_rem_left == 16'd0) begin
                        w_done  = 1'b1;
                        n_phase = PH_MASK_HI;
                    end
                end
                default: begin
                    n_phase = PH_MASK_HI;
                end
            endcase
        end
    end

    assign o_evt.done  = w_done;
    assign o_evt.bytes = n_fields;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MASK_HI;
            r_rem   <= '0;
        end else begin
            r_phase <= n_phase;
            r_rem   <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fields <= n_fields;
    end

endmodule
`default_nettype wire

FILE: sv/masked_row_to_mod_cells_unit.sv
// Pattern byte parser that turns each masked row into four tracker cells.
// Bytes are taken on every cycle while the drain buffer is free. When a byte
// completes a row, the row is copied into the drain buffer and its four cells
// leave through a registered output, one per cycle while the output is ready,
// channel 0 first; the first cell is then loaded into the output register from
// the buffer once the busy flag is set. While the buffer still holds cells, a
// mask low byte and a byte that would complete a row wait; the buffer frees as
// its fourth cell is loaded. Other bytes of the next row are still taken while
// the buffer drains, so parsing of a row overlaps the drain of the last one.
`default_nettype none
`include "assert_macros.svh"
module masked_row_to_mod_cells_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_pattern_start,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_channel,
    output logic [9:0]       o_period,
    output logic [7:0]       o_instr_effect,
    output logic [7:0]       o_effect_param,
    output logic             o_note_bad,
    output logic             o_row_last
);

    mrmc_pkg::t_row_evt   w_evt;
    mrmc_pkg::t_row_bytes r_buf;
    logic                 r_busy;
    logic [1:0]           r_cnt;
    logic                 w_load;

    logic                 r_out_valid;
    logic [1:0]           r_channel;
    logic [9:0]           r_period;
    logic [7:0]           r_instr_effect;
    logic [7:0]           r_effect_param;
    logic                 r_note_bad;

    logic [3:0][7:0]      w_chan;
    logic [7:0]           w_note;
    logic [7:0]           w_idx;
    logic [9:0]           n_period;
    logic                 n_note_bad;

    mrmc_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_byte      (i_in_byte),
        .i_start     (i_pattern_start),
        .i_emit_busy (r_busy),
        .o_ready     (o_in_ready),
        .o_evt       (w_evt)
    );

    // Cell of the channel being drained
    always_comb begin
        w_chan     = r_buf[r_cnt];
        w_note     = w_chan[0];
        n_period   = 10'd0;
        n_note_bad = 1'b0;
        if ((r_cnt == mrmc_pkg::LAST_CHANNEL) && (w_note > mrmc_pkg::HIGH_NOTE_LIMIT)) begin
            w_note = w_note - mrmc_pkg::HIGH_NOTE_DROP;
        end
        w_idx = w_note - 8'd1;
        if (w_note != 8'd0) begin
            if (w_idx < mrmc_pkg::NOTE_COUNT) begin
                n_period = mrmc_pkg::note_period(w_idx[5:0]);
            end else begin
                n_note_bad = 1'b1;
            end
        end
    end

    assign w_load = r_busy && (!r_out_valid || i_out_ready);

    // Drain buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cnt       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_evt.done) begin
                r_busy <= 1'b1;
                r_cnt  <= 2'd0;
            end else if (w_load) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == mrmc_pkg::LAST_CHANNEL) begin
                    r_busy <= 1'b0;
                end
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Row snapshot and output transaction payload
    always_ff @(posedge i_clk) begin
        if (w_evt.done) begin
            r_buf <= w_evt.bytes;
        end
        if (w_load) begin
            r_channel      <= r_cnt;
            r_period       <= n_period;
            r_instr_effect <= {w_chan[1][3:0], 4'b0000} | w_chan[2];
            r_effect_param <= w_chan[3];
            r_note_bad     <= n_note_bad;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_channel      = r_channel;
    assign o_period       = r_period;
    assign o_instr_effect = r_instr_effect;
    assign o_effect_param = r_effect_param;
    assign o_note_bad     = r_note_bad;
    assign o_row_last     = (r_channel == mrmc_pkg::LAST_CHANNEL);

    // A finished row never lands on cells still waiting to drain
    `ASSERT_CLK(a_no_overrun, w_evt.done |-> !r_busy, "row completed while buffer busy")
    // Draining the fourth cell frees the buffer
    `ASSERT_CLK(a_drain_end, (w_load && (r_cnt == mrmc_pkg::LAST_CHANNEL)) |=> !r_busy, "drain stuck")
    // Cells leave in channel order
    `ASSERT_CLK(a_chan_order, (r_busy && r_out_valid) |-> (r_cnt == 2'(r_channel + 2'd1)), "bad order")
    // Reset withdraws any offered result
    `ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule
`default_nettype wire
